FILE: design/jsds_pkg.sv
// shared types and constants for the jpeg frame header dimension scanner
`default_nettype none

package jsds_pkg;

    // byte counter width, 8 to 64
    localparam int SIZE_BITS   = 32;
    localparam int FILE_SIZE_W = 32;
    localparam int DIM_W       = 16;
    localparam int OFFSET_W    = 3;

    // marker byte values
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_SOF = 8'hC0;

    // byte offsets counted after the C0 byte (offsets 5..8 from the FF)
    localparam logic [OFFSET_W-1:0] OFF_HEIGHT_HI = 3'd4;
    localparam logic [OFFSET_W-1:0] OFF_HEIGHT_LO = 3'd5;
    localparam logic [OFFSET_W-1:0] OFF_WIDTH_HI  = 3'd6;
    localparam logic [OFFSET_W-1:0] OFF_WIDTH_LO  = 3'd7;
    localparam logic [OFFSET_W-1:0] OFF_DONE      = 3'd7;

    // magic byte positions
    localparam logic [SIZE_BITS-1:0] POS_MAGIC0 = SIZE_BITS'(0);
    localparam logic [SIZE_BITS-1:0] POS_MAGIC1 = SIZE_BITS'(1);
    localparam logic [SIZE_BITS-1:0] POS_MAGIC2 = SIZE_BITS'(2);
    localparam logic [SIZE_BITS-1:0] MAGIC_LEN  = SIZE_BITS'(3);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } jsds_in_t;

    typedef struct packed {
        logic                   is_jpeg;
        logic                   header_found;
        logic [DIM_W-1:0]       image_height;
        logic [DIM_W-1:0]       image_width;
        logic [FILE_SIZE_W-1:0] file_size;
    } jsds_out_t;

    // scanner to result register
    typedef struct packed {
        logic      load;
        jsds_out_t result;
    } jsds_res_load_t;

endpackage

`default_nettype wire

FILE: design/jsds_in_stage.sv
// input register for byte requests
`default_nettype none

module jsds_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire jsds_pkg::jsds_in_t req_data,
    input  wire logic             advance,
    output logic                  held_valid,
    output jsds_pkg::jsds_in_t    held_data
);
    import jsds_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    jsds_in_t data_reg;
    logic     load;

    assign req_stall  = valid_reg && !advance;
    assign load       = req_valid && !req_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= req_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/jsds_scan.sv
// per-file scan state: magic check, marker search, dimension capture, byte count
`default_nettype none

module jsds_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire jsds_pkg::jsds_in_t   held_data,
    output jsds_pkg::jsds_res_load_t  res_load
);
    import jsds_pkg::*;

    localparam logic [SIZE_BITS-1:0] COUNT_MAX = '1;

    logic [SIZE_BITS-1:0] count_reg, count_next;
    logic                 magic_reg, magic_next;
    logic                 prev_ff_reg, prev_ff_next;
    logic                 marker_reg, marker_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic [DIM_W-1:0]     height_reg, height_next;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [FILE_SIZE_W-1:0] size_val;
    logic                 found;

    always_comb
    begin
        logic [7:0] b;
        b = held_data.data_byte;

        magic_next = magic_reg;
        if (count_reg == POS_MAGIC0 && b != BYTE_FF)
        begin
            magic_next = 1'b0;
        end
        if (count_reg == POS_MAGIC1 && b != BYTE_SOI)
        begin
            magic_next = 1'b0;
        end
        if (count_reg == POS_MAGIC2 && b != BYTE_FF)
        begin
            magic_next = 1'b0;
        end

        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        marker_next = marker_reg;
        offset_next = offset_reg;
        height_next = height_reg;
        width_next  = width_reg;
        if (marker_reg)
        begin
            if (offset_reg < OFF_DONE)
            begin
                offset_next = offset_reg + 1'b1;
                case (offset_next)
                    OFF_HEIGHT_HI: height_next[15:8] = b;
                    OFF_HEIGHT_LO: height_next[7:0]  = b;
                    OFF_WIDTH_HI:  width_next[15:8]  = b;
                    OFF_WIDTH_LO:  width_next[7:0]   = b;
                    default:       ;
                endcase
            end
        end
        else if (prev_ff_reg && b == BYTE_SOF)
        begin
            marker_next = 1'b1;
            offset_next = '0;
        end

        prev_ff_next = (b == BYTE_FF);
    end

    // clamp the count to the result field
    generate
        if (SIZE_BITS > FILE_SIZE_W)
        begin : g_size_sat
            assign size_val = (|count_next[SIZE_BITS-1:FILE_SIZE_W]) ? '1
                                                                   : count_next[FILE_SIZE_W-1:0];
        end
        else
        begin : g_size_ext
            assign size_val = FILE_SIZE_W'(count_next);
        end
    endgenerate

    assign found = marker_next && (offset_next == OFF_DONE);

    assign res_load.load                = advance && held_data.last_byte;
    assign res_load.result.is_jpeg      = magic_next && (count_next >= MAGIC_LEN);
    assign res_load.result.header_found = found;
    assign res_load.result.image_height = found ? height_next : '0;
    assign res_load.result.image_width  = found ? width_next : '0;
    assign res_load.result.file_size    = size_val;

    // control state; back to reset values after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            magic_reg   <= 1'b1;
            prev_ff_reg <= 1'b0;
            marker_reg  <= 1'b0;
            offset_reg  <= '0;
        end
        else if (advance)
        begin
            if (held_data.last_byte)
            begin
                count_reg   <= '0;
                magic_reg   <= 1'b1;
                prev_ff_reg <= 1'b0;
                marker_reg  <= 1'b0;
                offset_reg  <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                magic_reg   <= magic_next;
                prev_ff_reg <= prev_ff_next;
                marker_reg  <= marker_next;
                offset_reg  <= offset_next;
            end
        end
    end

    // dimensions are only reported once all four bytes are rewritten
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            height_reg <= height_next;
            width_reg  <= width_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/jsds_out_reg.sv
// result register toward the consumer
`default_nettype none

module jsds_out_reg (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire jsds_pkg::jsds_res_load_t res_load,
    output logic                         free,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output jsds_pkg::jsds_out_t          res_data
);
    import jsds_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    jsds_out_t data_reg;

    assign free       = !valid_reg || !res_stall;
    assign valid_next = res_load.load || (valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load.load)
        begin
            data_reg <= res_load.result;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/jpeg_sof_dimension_scan_core.sv
// top level: jpeg frame header dimension scanner over a byte stream
// a byte request is first registered in the input register and then scanned; a last byte's
//   result is then registered in the result register, where res_valid shows it
// throughput: one byte per cycle; the input register holds only while a last byte
//   waits for the result register, which frees when the consumer takes the result
// reset: asynchronous, active low; clears the scan state and both valid flags
`default_nettype none

module jpeg_sof_dimension_scan_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // byte requests
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire jsds_pkg::jsds_in_t  req_data,
    // per-file results
    output logic                     res_valid,
    input  wire logic                res_stall,
    output jsds_pkg::jsds_out_t      res_data
);
    import jsds_pkg::*;

    logic           held_valid;
    jsds_in_t       held_data;
    logic           advance;
    logic           out_free;
    jsds_res_load_t res_load;

    // a held byte moves on unless it closes a file and the result slot is busy
    assign advance = held_valid && (!held_data.last_byte || out_free);

    // input register: parts the producer from the scan logic
    jsds_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    // scan state and result formation, one byte per cycle unless a last byte waits for the result slot
    jsds_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .held_data (held_data),
        .res_load  (res_load)
    );

    // result register: keeps a finished result while new bytes flow in
    jsds_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // dimensions are zero whenever no complete frame header was seen
    a_dims_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.header_found |->
            res_data.image_height == '0 && res_data.image_width == '0)
        else $error("dimensions reported without a frame header");

    // a file marked jpeg has at least the three magic bytes
    a_jpeg_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.is_jpeg |-> res_data.file_size >= FILE_SIZE_W'(3))
        else $error("jpeg flag on a file shorter than the magic");

    // a scanned last byte always lands in the result register
    a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && held_data.last_byte |=> res_valid)
        else $error("last byte scanned but no result");

    // the input side holds only when a last byte is blocked on the result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> held_valid && held_data.last_byte && res_valid && res_stall)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

FILE: verif/jsds_result_checker.sv
// checker for the jpeg frame header scanner: predicts each file's result and compares it

module jsds_result_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  jsds_pkg::jsds_in_t      req_data,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  jsds_pkg::jsds_out_t     res_data,
    output int unsigned             mismatch_count,
    output int unsigned             files_outstanding
);

    import jsds_pkg::*;

    localparam logic [SIZE_BITS-1:0] COUNT_MAX = '1;
    localparam logic [63:0] FILE_SIZE_MAX = 64'({FILE_SIZE_W{1'b1}});

    // predicted scan state
    logic [SIZE_BITS-1:0] scan_count  = '0;
    logic                 magic_good  = 1'b1;
    logic                 last_was_ff = 1'b0;
    logic                 sof_seen    = 1'b0;
    logic [OFFSET_W-1:0]  sof_offset  = '0;
    logic [DIM_W-1:0]     height_capt = '0;
    logic [DIM_W-1:0]     width_capt  = '0;

    // results of completed files, oldest first
    jsds_out_t expected_files[$];

    int unsigned fail_tally = 0;
    int unsigned pending    = 0;

    assign mismatch_count    = fail_tally;
    assign files_outstanding = pending;

    task automatic clear_scan();
        scan_count  = '0;
        magic_good  = 1'b1;
        last_was_ff = 1'b0;
        sof_seen    = 1'b0;
        sof_offset  = '0;
        height_capt = '0;
        width_capt  = '0;
    endtask

    task automatic scan_byte(input jsds_in_t req);
        logic [7:0]  data;
        logic        found;
        logic [63:0] wide_count;
        jsds_out_t   file_res;
        data = req.data_byte;

        if (scan_count == POS_MAGIC0 && data != BYTE_FF)  magic_good = 1'b0;
        if (scan_count == POS_MAGIC1 && data != BYTE_SOI) magic_good = 1'b0;
        if (scan_count == POS_MAGIC2 && data != BYTE_FF)  magic_good = 1'b0;

        if (scan_count != COUNT_MAX) scan_count = scan_count + 1'b1;

        // only the first sof marker counts, later bytes are just counted
        if (sof_seen) begin
            if (sof_offset != OFF_DONE) begin
                sof_offset = sof_offset + 1'b1;
                case (sof_offset)
                    OFF_HEIGHT_HI: height_capt[15:8] = data;
                    OFF_HEIGHT_LO: height_capt[7:0]  = data;
                    OFF_WIDTH_HI:  width_capt[15:8]  = data;
                    OFF_WIDTH_LO:  width_capt[7:0]   = data;
                    default: ;
                endcase
            end
        end else if (last_was_ff && data == BYTE_SOF) begin
            sof_seen   = 1'b1;
            sof_offset = '0;
        end
        last_was_ff = (data == BYTE_FF);

        if (req.last_byte) begin
            found      = sof_seen && sof_offset == OFF_DONE;
            wide_count = 64'(scan_count);
            file_res.is_jpeg      = magic_good && scan_count >= MAGIC_LEN;
            file_res.header_found = found;
            file_res.image_height = found ? height_capt : '0;
            file_res.image_width  = found ? width_capt : '0;
            file_res.file_size    = (wide_count > FILE_SIZE_MAX) ? '1
                                                                 : wide_count[FILE_SIZE_W-1:0];
            expected_files.push_back(file_res);
            clear_scan();
        end
    endtask

    task automatic check_file(input jsds_out_t got);
        jsds_out_t want;
        if (expected_files.size() == 0) begin
            $error("result with no file pending: size %0d", got.file_size);
            fail_tally++;
        end else begin
            want = expected_files.pop_front();
            if (got.is_jpeg !== want.is_jpeg) begin
                $error("is_jpeg: expected %0d, got %0d", want.is_jpeg, got.is_jpeg);
                fail_tally++;
            end
            if (got.header_found !== want.header_found) begin
                $error("header_found: expected %0d, got %0d",
                       want.header_found, got.header_found);
                fail_tally++;
            end
            if (got.image_height !== want.image_height) begin
                $error("image_height: expected %0d, got %0d",
                       want.image_height, got.image_height);
                fail_tally++;
            end
            if (got.image_width !== want.image_width) begin
                $error("image_width: expected %0d, got %0d",
                       want.image_width, got.image_width);
                fail_tally++;
            end
            if (got.file_size !== want.file_size) begin
                $error("file_size: expected %0d, got %0d", want.file_size, got.file_size);
                fail_tally++;
            end
        end
    endtask

    // results are matched before the byte of the same edge is scanned
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_files.delete();
        end
        else
        begin
            if (res_valid && !res_stall) check_file(res_data);
            if (req_valid && !req_stall) scan_byte(req_data);
        end
        pending = expected_files.size();
    end

endmodule

FILE: verif/jpeg_sof_dimension_scan_core_tb.sv
// testbench top for the jpeg frame header scanner: stimulus, idling phases and verdict

module jpeg_sof_dimension_scan_core_tb;

    import jsds_pkg::*;

    // cycle limit for the watchdog, with ample room for the slowest run
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // minimum bytes per idling phase, four phases make up the random part
    localparam int unsigned PHASE_BYTES   = 160;
    // idle wait before the verdict, once every result is back
    localparam int unsigned SETTLE_CYCLES = 8;
    // long receiver hold-off used to back the block up
    localparam int unsigned HOLD_CYCLES   = 300;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    jsds_in_t  req_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    jsds_out_t res_data;

    int unsigned mismatch_count;
    int unsigned files_outstanding;

    int unsigned cycle_count      = 0;
    int unsigned send_idle_pct    = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned long_hold_cycles = 0;
    int unsigned phase_bytes      = 0;

    // bytes of the file about to be sent, the last one carries the last flag
    logic [7:0] file_bytes[$];

    jpeg_sof_dimension_scan_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    jsds_result_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req_data          (req_data),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .res_data          (res_data),
        .mismatch_count    (mismatch_count),
        .files_outstanding (files_outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake or a lost result ends here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side: a long hold-off when one is armed, otherwise random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles != 0)
            begin
                res_stall <= 1'b1;
                long_hold_cycles--;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // bytes that matter to the scanner, mixed with plain random ones
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return BYTE_FF;
            1:       return BYTE_SOF;
            2:       return BYTE_SOI;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // send every byte of file_bytes as one request each, then empty the queue;
    // idle gaps come before a request, never while one is waiting
    task automatic send_file();
        int idx;
        for (idx = 0; idx < file_bytes.size(); idx++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            req_valid <= 1'b1;
            req_data  <= '{data_byte: file_bytes[idx],
                           last_byte: (idx == file_bytes.size() - 1)};
            @(posedge clk);
            // hold the request, unchanged, until it is taken
            while (req_stall) @(posedge clk);
            phase_bytes++;
        end
        file_bytes.delete();
    endtask

    // sender goes quiet until every finished file has its result back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (files_outstanding != 0) @(posedge clk);
    endtask

    // one random file; mostly well-formed headers with random content so the
    // dimension capture is exercised, the rest noise, broken and short files
    task automatic build_random_file();
        int unsigned kind;
        int unsigned cut;
        int unsigned idx;
        kind = $urandom_range(9);
        if (kind <= 6)
        begin
            file_bytes = {BYTE_FF, BYTE_SOI, BYTE_FF};
            // damaged magic
            if (kind == 5) file_bytes[$urandom_range(2)] = 8'($urandom_range(255));
            repeat ($urandom_range(4)) file_bytes.push_back(8'($urandom_range(254)));
            // a stray marker before the frame header
            if ($urandom_range(3) == 0)
            begin
                file_bytes.push_back(BYTE_FF);
                file_bytes.push_back(pick_byte());
            end
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(BYTE_SOF);
            // length, precision, height and width; truncated files stop early
            cut = (kind == 6) ? $urandom_range(6) : 7;
            for (idx = 0; idx < cut; idx++) file_bytes.push_back(8'($urandom_range(255)));
            // trailing bytes, which may hold later markers
            if (kind != 6)
                repeat ($urandom_range(5)) file_bytes.push_back(pick_byte());
        end
        else if (kind <= 8)
        begin
            repeat ($urandom_range(14, 1)) file_bytes.push_back(pick_byte());
        end
        else
        begin
            repeat ($urandom_range(2, 1)) file_bytes.push_back(pick_byte());
        end
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        phase_bytes    = 0;
        while (phase_bytes < PHASE_BYTES)
        begin
            build_random_file();
            send_file();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-byte file, too short to be a jpeg
        file_bytes = {8'h00};
        send_file();
        // bare magic, no frame header
        file_bytes = {BYTE_FF, BYTE_SOI, BYTE_FF};
        send_file();
        // marker overlapping the magic, height all ones and width all zeros
        file_bytes = {BYTE_FF, BYTE_SOF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_file();
        // marker on the third magic byte, header cut off before the dimensions
        file_bytes = {BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOF, 8'h00, 8'h11, 8'h22};
        send_file();
        wait_drained();

        // random part across the idling phases
        run_phase(0, 0);

        // back the block up: long result hold-off while short files keep coming
        long_hold_cycles = HOLD_CYCLES;
        repeat (10)
        begin
            build_random_file();
            send_file();
        end
        wait_drained();

        run_phase(79, 0);
        run_phase(0, 79);
        run_phase(31, 31);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && files_outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
